### rtl/core/tvs_pkg.sv
package tvs_pkg;

    localparam int SIZE_W     = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int VOXEL_W    = 16;
    localparam int VADDR_W    = 18;
    localparam int COORD_W    = 20;
    localparam int S_TDATA_W  = 96;
    localparam int M_TDATA_W  = 16;
    localparam int Q_DEPTH    = 8;
    localparam int NB         = 8;   // neighbors per sample, one store copy each

    localparam logic [CFG_IDX_W-1:0] REG_SIZE_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_Z = 2'd2;

    typedef struct packed {
        logic [SIZE_W-1:0] sx;
        logic [SIZE_W-1:0] sy;
        logic [SIZE_W-1:0] sz;
    } vol_size_t;

endpackage

### rtl/core/tvs_queue.sv
module tvs_queue #(
    parameter int W = 8
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   push,
    input  logic [W-1:0]                           din,
    input  logic                                   pop,
    output logic [W-1:0]                           dout,
    output logic                                   not_empty,
    output logic [$clog2(tvs_pkg::Q_DEPTH+1)-1:0]  count
);
    localparam int PTR_W = $clog2(tvs_pkg::Q_DEPTH);
    localparam int CNT_W = $clog2(tvs_pkg::Q_DEPTH+1);

    logic [W-1:0]     slot_reg [tvs_pkg::Q_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    always_comb begin
        wr_ptr_next = push ? PTR_W'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = pop  ? PTR_W'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = CNT_W'(count_reg + 1'b1);
        end else if (pop && !push) begin
            count_next = CNT_W'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= din;
        end
    end

    assign dout      = slot_reg[rd_ptr_reg];
    assign not_empty = (count_reg != '0);
    assign count     = count_reg;

endmodule

### rtl/core/tvs_front.sv
module tvs_front #(
    parameter int MAX_EDGE        = 64,
    parameter int COORD_FRAC_BITS = 8,
    parameter int ADW             = 18,
    parameter int QW              = 8
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               in_valid,
    input  logic                               in_mode,
    input  logic [tvs_pkg::VADDR_W-1:0]        in_addr,
    input  logic [tvs_pkg::VOXEL_W-1:0]        in_value,
    input  logic [tvs_pkg::COORD_W-1:0]        in_cx,
    input  logic [tvs_pkg::COORD_W-1:0]        in_cy,
    input  logic [tvs_pkg::COORD_W-1:0]        in_cz,
    input  tvs_pkg::vol_size_t                 size,
    output logic [1:0]                         in_flight,
    output logic                               push,
    output logic [QW-1:0]                      push_data
);
    localparam int FB    = COORD_FRAC_BITS;
    localparam int CW    = $clog2(MAX_EDGE);
    localparam int DEPTH = MAX_EDGE * MAX_EDGE * MAX_EDGE;
    localparam int WAW   = (ADW > tvs_pkg::VADDR_W) ? ADW : tvs_pkg::VADDR_W;
    localparam int PW    = CW + 2 * tvs_pkg::SIZE_W;
    localparam int XW    = tvs_pkg::COORD_W + 1;
    localparam logic [8:0] EMAX = 9'(MAX_EDGE);

    function automatic logic [tvs_pkg::SIZE_W-1:0] eff_size(logic [tvs_pkg::SIZE_W-1:0] r);
        logic [tvs_pkg::SIZE_W-1:0] e;
        if (r == '0) begin
            e = tvs_pkg::SIZE_W'(1);
        end else if ({2'b00, r} > EMAX) begin
            e = tvs_pkg::SIZE_W'(EMAX);
        end else begin
            e = r;
        end
        return e;
    endfunction

    function automatic logic [CW-1:0] clamp_axis(logic signed [XW-1:0] p,
                                                 logic [tvs_pkg::SIZE_W-1:0] n);
        logic [CW-1:0] c;
        if (p < 0) begin
            c = '0;
        end else if (p >= $signed(XW'(n))) begin
            c = CW'(n - 1'b1);
        end else begin
            c = CW'(p);
        end
        return c;
    endfunction

    logic [tvs_pkg::SIZE_W-1:0] sx, sy, sz;
    logic [2*tvs_pkg::SIZE_W-1:0] sxy_reg;

    // stage 1: captured word
    logic                         v1_reg, mode1_reg;
    logic [tvs_pkg::VADDR_W-1:0]  addr1_reg;
    logic [tvs_pkg::VOXEL_W-1:0]  value1_reg;
    logic [tvs_pkg::COORD_W-1:0]  cx1_reg, cy1_reg, cz1_reg;

    // stage 2: classified, clamped
    logic                         v2_reg, smp2_reg, we2_reg;
    logic [ADW-1:0]               waddr2_reg;
    logic [tvs_pkg::VOXEL_W-1:0]  wdata2_reg;
    logic [CW-1:0]                x0_reg, x1_reg, y0_reg, y1_reg, z0_reg, z1_reg;
    logic [FB-1:0]                fx_reg, fy_reg, fz_reg;

    logic signed [XW-1:0] ix, iy, iz;
    logic [WAW-1:0]       waddr_ext;
    logic [PW-1:0]        zt [2];
    logic [PW-1:0]        yt [2];
    logic [PW-1:0]        lin [tvs_pkg::NB];
    logic [tvs_pkg::NB*ADW-1:0] addr_flat;

    assign sx = eff_size(size.sx);
    assign sy = eff_size(size.sy);
    assign sz = eff_size(size.sz);

    // arithmetic shift floors toward minus infinity
    assign ix = $signed(XW'($signed(cx1_reg))) >>> FB;
    assign iy = $signed(XW'($signed(cy1_reg))) >>> FB;
    assign iz = $signed(XW'($signed(cz1_reg))) >>> FB;
    assign waddr_ext = WAW'(addr1_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        sxy_reg    <= (2*tvs_pkg::SIZE_W)'(sx) * (2*tvs_pkg::SIZE_W)'(sy);
        mode1_reg  <= in_mode;
        addr1_reg  <= in_addr;
        value1_reg <= in_value;
        cx1_reg    <= in_cx;
        cy1_reg    <= in_cy;
        cz1_reg    <= in_cz;

        smp2_reg   <= mode1_reg;
        // one extra bit so the store depth itself does not wrap to zero
        we2_reg    <= !mode1_reg && ({1'b0, waddr_ext} < (WAW+1)'(DEPTH));
        waddr2_reg <= ADW'(waddr_ext);
        wdata2_reg <= value1_reg;
        x0_reg     <= clamp_axis(ix, sx);
        x1_reg     <= clamp_axis(XW'(ix + 1'b1), sx);
        y0_reg     <= clamp_axis(iy, sy);
        y1_reg     <= clamp_axis(XW'(iy + 1'b1), sy);
        z0_reg     <= clamp_axis(iz, sz);
        z1_reg     <= clamp_axis(XW'(iz + 1'b1), sz);
        fx_reg     <= cx1_reg[FB-1:0];
        fy_reg     <= cy1_reg[FB-1:0];
        fz_reg     <= cz1_reg[FB-1:0];
    end

    // linear addresses; neighbor k takes x from bit 0, y from bit 1, z from bit 2
    always_comb begin
        zt[0] = PW'(z0_reg) * PW'(sxy_reg);
        zt[1] = PW'(z1_reg) * PW'(sxy_reg);
        yt[0] = PW'(y0_reg) * PW'(sx);
        yt[1] = PW'(y1_reg) * PW'(sx);
        for (int k = 0; k < tvs_pkg::NB; k++) begin
            lin[k] = zt[k[2]] + yt[k[1]] + PW'(k[0] ? x1_reg : x0_reg);
            addr_flat[k*ADW +: ADW] = ADW'(lin[k]);
        end
        // a write carries its address in the first slot
        if (!smp2_reg) begin
            addr_flat[ADW-1:0] = waddr2_reg;
        end
    end

    assign push      = v2_reg && (smp2_reg || we2_reg);
    assign push_data = {fz_reg, fy_reg, fx_reg, addr_flat, wdata2_reg, we2_reg, smp2_reg};
    assign in_flight = {1'b0, v1_reg} + {1'b0, v2_reg};

endmodule

### rtl/core/tvs_back.sv
module tvs_back #(
    parameter int MAX_EDGE        = 64,
    parameter int COORD_FRAC_BITS = 8,
    parameter int ADW             = 18,
    parameter int QW              = 8
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             q_valid,
    input  logic [QW-1:0]                    q_data,
    output logic                             pop,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [tvs_pkg::VOXEL_W-1:0]      m_data
);
    localparam int FB    = COORD_FRAC_BITS;
    localparam int DEPTH = MAX_EDGE * MAX_EDGE * MAX_EDGE;
    localparam int VW    = tvs_pkg::VOXEL_W;
    localparam int PW    = VW + FB + 2;
    localparam int AOFF  = VW + 2;
    localparam int FOFF  = AOFF + tvs_pkg::NB * ADW;

    logic en;
    logic q_smp, q_we;
    logic [VW-1:0]  q_wdata;
    logic [FB-1:0]  q_fx, q_fy, q_fz;

    logic                 vm_reg, va_reg, vb_reg, vc_reg, out_v_reg;
    logic [VW-1:0]        rd_reg [tvs_pkg::NB];
    logic [FB-1:0]        fxm_reg, fym_reg, fzm_reg, fya_reg, fza_reg, fzb_reg;
    logic [VW-1:0]        ax_reg [4];
    logic signed [PW-1:0] px_reg [4];
    logic [VW-1:0]        ay_reg [2];
    logic signed [PW-1:0] py_reg [2];
    logic [VW-1:0]        az_reg;
    logic signed [PW-1:0] pz_reg;
    logic [VW-1:0]        out_reg;

    logic signed [PW-1:0] px_next [4];
    logic [VW-1:0]        u [4];
    logic signed [PW-1:0] py_next [2];
    logic [VW-1:0]        w [2];
    logic signed [PW-1:0] pz_next;
    logic [VW-1:0]        r;

    function automatic logic signed [PW-1:0] diff_mul(logic [VW-1:0] a, logic [VW-1:0] b,
                                                       logic [FB-1:0] f);
        logic signed [VW:0] d;
        d = $signed({1'b0, b}) - $signed({1'b0, a});
        return PW'(d) * $signed(PW'({1'b0, f}));
    endfunction

    function automatic logic [VW-1:0] add_step(logic [VW-1:0] a, logic signed [PW-1:0] p);
        logic signed [PW-1:0] s;
        s = $signed(PW'({1'b0, a})) + (p >>> FB);
        return s[VW-1:0];
    endfunction

    assign en      = !out_v_reg || m_ready;
    assign pop     = en && q_valid;
    assign q_smp   = q_data[0];
    assign q_we    = q_data[1];
    assign q_wdata = q_data[2 +: VW];
    assign q_fx    = q_data[FOFF +: FB];
    assign q_fy    = q_data[FOFF + FB +: FB];
    assign q_fz    = q_data[FOFF + 2*FB +: FB];

    // one full copy of the volume per neighbor so all eight read at once
    for (genvar k = 0; k < tvs_pkg::NB; k++) begin : g_copy
        logic [VW-1:0] mem [DEPTH];
        always_ff @(posedge aclk) begin
            if (pop && q_we) begin
                mem[q_data[AOFF +: ADW]] <= q_wdata;
            end
            if (en) begin
                rd_reg[k] <= mem[q_data[AOFF + k*ADW +: ADW]];
            end
        end
    end

    always_comb begin
        for (int j = 0; j < 4; j++) begin
            px_next[j] = diff_mul(rd_reg[2*j], rd_reg[2*j+1], fxm_reg);
            u[j]       = add_step(ax_reg[j], px_reg[j]);
        end
        for (int m = 0; m < 2; m++) begin
            py_next[m] = diff_mul(u[2*m], u[2*m+1], fya_reg);
            w[m]       = add_step(ay_reg[m], py_reg[m]);
        end
        pz_next = diff_mul(w[0], w[1], fzb_reg);
        r       = add_step(az_reg, pz_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vm_reg    <= 1'b0;
            va_reg    <= 1'b0;
            vb_reg    <= 1'b0;
            vc_reg    <= 1'b0;
            out_v_reg <= 1'b0;
        end else if (en) begin
            vm_reg    <= pop && q_smp;
            va_reg    <= vm_reg;
            vb_reg    <= va_reg;
            vc_reg    <= vb_reg;
            out_v_reg <= vc_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            fxm_reg <= q_fx;
            fym_reg <= q_fy;
            fzm_reg <= q_fz;
            for (int j = 0; j < 4; j++) begin
                ax_reg[j] <= rd_reg[2*j];
                px_reg[j] <= px_next[j];
            end
            fya_reg <= fym_reg;
            fza_reg <= fzm_reg;
            for (int m = 0; m < 2; m++) begin
                ay_reg[m] <= u[2*m];
                py_reg[m] <= py_next[m];
            end
            fzb_reg <= fza_reg;
            az_reg  <= w[0];
            pz_reg  <= pz_next;
            out_reg <= r;
        end
    end

    assign m_valid = out_v_reg;
    assign m_data  = out_reg;

endmodule

### rtl/core/trilinear_volume_sampler.sv
// Channel   Dir  Handshake               Payload
// s_        in   s_tvalid / s_tready     s_tuser mode; s_tdata address, voxel, coords
// m_        out  m_tvalid / m_tready     m_tdata sample_value
// cfg_      in   cfg_valid / cfg_ready   cfg_index register, cfg_data size
//
// One word per cycle in and one sample per cycle out unless s_tready or m_tready holds
// the flow; m_tvalid rises after the word passes two front stages, a queue slot, the
// store read, three blend stages and the output register.
// The eight-neighbor read is served by eight copies of the voxel store, each written
// by every store word and read at one neighbor address per cycle unless m_tready stalls.
// Reset is synchronous, active low; sizes reset to 64, the voxel store is not cleared.
// s_tready drops only when the queue plus words still in the front stages fills it,
// which happens when m_tready holds the blend pipeline.
module trilinear_volume_sampler #(
    parameter int MAX_EDGE        = 64,
    parameter int COORD_FRAC_BITS = 8
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [17:0] voxel_address, [33:18] voxel_value, [53:34] coord_x,
    // [73:54] coord_y, [93:74] coord_z, [95:94] zero
    input  logic [tvs_pkg::S_TDATA_W-1:0]       s_tdata,
    // [0] mode
    input  logic                                s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [15:0] sample_value
    output logic [tvs_pkg::M_TDATA_W-1:0]       m_tdata,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [tvs_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [tvs_pkg::SIZE_W-1:0]          cfg_data
);
    localparam int ADW   = $clog2(MAX_EDGE * MAX_EDGE * MAX_EDGE);
    localparam int QW    = 2 + tvs_pkg::VOXEL_W + tvs_pkg::NB * ADW + 3 * COORD_FRAC_BITS;
    localparam int CNT_W = $clog2(tvs_pkg::Q_DEPTH + 1);
    localparam int FW    = CNT_W + 1;

    tvs_pkg::vol_size_t size_reg;

    logic [1:0]        in_flight;
    logic              push, pop, q_valid;
    logic [QW-1:0]     push_data, q_data;
    logic [CNT_W-1:0]  q_count;
    logic [FW-1:0]     fill;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_reg.sx <= 7'd64;
            size_reg.sy <= 7'd64;
            size_reg.sz <= 7'd64;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                tvs_pkg::REG_SIZE_X: size_reg.sx <= cfg_data;
                tvs_pkg::REG_SIZE_Y: size_reg.sy <= cfg_data;
                tvs_pkg::REG_SIZE_Z: size_reg.sz <= cfg_data;
                default: ;
            endcase
        end
    end

    // credit: every word in the front stages owns a queue slot
    assign fill     = FW'(q_count) + FW'(in_flight);
    assign s_tready = (fill < FW'(tvs_pkg::Q_DEPTH));

    tvs_front #(
        .MAX_EDGE        (MAX_EDGE),
        .COORD_FRAC_BITS (COORD_FRAC_BITS),
        .ADW             (ADW),
        .QW              (QW)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid && s_tready),
        .in_mode   (s_tuser),
        .in_addr   (s_tdata[17:0]),
        .in_value  (s_tdata[33:18]),
        .in_cx     (s_tdata[53:34]),
        .in_cy     (s_tdata[73:54]),
        .in_cz     (s_tdata[93:74]),
        .size      (size_reg),
        .in_flight (in_flight),
        .push      (push),
        .push_data (push_data)
    );

    tvs_queue #(
        .W (QW)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .din       (push_data),
        .pop       (pop),
        .dout      (q_data),
        .not_empty (q_valid),
        .count     (q_count)
    );

    tvs_back #(
        .MAX_EDGE        (MAX_EDGE),
        .COORD_FRAC_BITS (COORD_FRAC_BITS),
        .ADW             (ADW),
        .QW              (QW)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .q_data  (q_data),
        .pop     (pop),
        .m_valid (m_tvalid),
        .m_ready (m_tready),
        .m_data  (m_tdata)
    );

endmodule

### dv/trilinear_volume_sampler_tb.sv
`timescale 1ns / 100ps

module trilinear_volume_sampler_tb;

    localparam int EDGE       = 64;
    localparam int FRAC       = 8;
    localparam int DEPTH      = EDGE * EDGE * EDGE;
    localparam int LIMIT      = 1000000;
    localparam int DRAIN      = 30;
    localparam logic [tvs_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    typedef enum logic { MODE_WRITE = 1'b0, MODE_SAMPLE = 1'b1 } mode_e;

    typedef struct packed {
        mode_e                               mode;
        logic [tvs_pkg::VADDR_W-1:0]         addr;
        logic [tvs_pkg::VOXEL_W-1:0]         voxel;
        logic signed [tvs_pkg::COORD_W-1:0]  cx;
        logic signed [tvs_pkg::COORD_W-1:0]  cy;
        logic signed [tvs_pkg::COORD_W-1:0]  cz;
    } word_t;

    typedef struct packed {
        logic [tvs_pkg::CFG_IDX_W-1:0] idx;
        logic [tvs_pkg::SIZE_W-1:0]    val;
    } reg_wr_t;

    logic                            aclk;
    logic                            aresetn;
    logic                            s_tvalid;
    logic                            s_tready;
    logic [tvs_pkg::S_TDATA_W-1:0]   s_tdata;
    logic                            s_tuser;
    logic                            m_tvalid;
    logic                            m_tready;
    logic [tvs_pkg::M_TDATA_W-1:0]   m_tdata;
    logic                            cfg_valid;
    logic                            cfg_ready;
    logic [tvs_pkg::CFG_IDX_W-1:0]   cfg_index;
    logic [tvs_pkg::SIZE_W-1:0]      cfg_data;

    trilinear_volume_sampler dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // pending stimulus and expected samples
    word_t          pending_words[$];
    reg_wr_t        pending_regs[$];
    logic [15:0]    expected_samples[$];

    // predictor state, updated on accepted words and register writes
    logic [15:0]    vol_store [0:DEPTH-1];
    logic [6:0]     pred_sx, pred_sy, pred_sz;

    // generator state: which voxels have been loaded, sizes in force
    bit             loaded [0:DEPTH-1];
    int             gen_sx, gen_sy, gen_sz;

    word_t          cur_word;
    int             send_gap, recv_gap;
    bit             hold_send, no_idle;
    int             cycles, errors, n_samples, n_writes, n_regs, n_results, n_gen;

    function automatic int eff_size(int r);
        if (r == 0) return 1;
        if (r > EDGE) return EDGE;
        return r;
    endfunction

    function automatic int clamp(longint p, int n);
        if (p < 0) return 0;
        if (p >= n) return n - 1;
        return int'(p);
    endfunction

    function automatic longint blend(longint a, longint b, longint f);
        return a + (((b - a) * f) >>> FRAC);
    endfunction

    // the eight neighbor addresses of a sample, index bit0=x, bit1=y, bit2=z
    function automatic void corner_addrs(word_t w, int sx, int sy, int sz,
                                         output int addrs[8]);
        longint ix, iy, iz;
        int xs[2], ys[2], zs[2];
        ix = longint'(w.cx) >>> FRAC;
        iy = longint'(w.cy) >>> FRAC;
        iz = longint'(w.cz) >>> FRAC;
        xs[0] = clamp(ix, sx); xs[1] = clamp(ix + 1, sx);
        ys[0] = clamp(iy, sy); ys[1] = clamp(iy + 1, sy);
        zs[0] = clamp(iz, sz); zs[1] = clamp(iz + 1, sz);
        for (int k = 0; k < 8; k++)
            addrs[k] = zs[k[2]] * sx * sy + ys[k[1]] * sx + xs[k[0]];
    endfunction

    function automatic logic [15:0] interp_sample(word_t w);
        int a[8];
        longint v[8], t1, t2, t3, t4, t5, t6;
        longint fx, fy, fz;
        corner_addrs(w, eff_size(pred_sx), eff_size(pred_sy), eff_size(pred_sz), a);
        for (int k = 0; k < 8; k++) v[k] = longint'(vol_store[a[k]]);
        fx = longint'(w.cx[FRAC-1:0]);
        fy = longint'(w.cy[FRAC-1:0]);
        fz = longint'(w.cz[FRAC-1:0]);
        t1 = blend(v[0], v[1], fx);
        t2 = blend(v[4], v[5], fx);
        t3 = blend(v[2], v[3], fx);
        t4 = blend(v[6], v[7], fx);
        t5 = blend(t1, t3, fy);
        t6 = blend(t2, t4, fy);
        return 16'(blend(t5, t6, fz));
    endfunction

    task automatic push_write(int addr, logic [15:0] val);
        word_t w;
        w.mode  = MODE_WRITE;
        w.addr  = tvs_pkg::VADDR_W'(addr);
        w.voxel = val;
        w.cx    = tvs_pkg::COORD_W'($urandom);
        w.cy    = tvs_pkg::COORD_W'($urandom);
        w.cz    = tvs_pkg::COORD_W'($urandom);
        loaded[addr] = 1;
        n_gen++;
        pending_words.push_back(w);
    endtask

    // loads any unloaded neighbor first so a sample never reads an empty voxel
    task automatic push_sample(int cx, int cy, int cz);
        word_t w;
        int a[8];
        w.mode  = MODE_SAMPLE;
        w.addr  = tvs_pkg::VADDR_W'($urandom);
        w.voxel = tvs_pkg::VOXEL_W'($urandom);
        w.cx    = tvs_pkg::COORD_W'(cx);
        w.cy    = tvs_pkg::COORD_W'(cy);
        w.cz    = tvs_pkg::COORD_W'(cz);
        corner_addrs(w, eff_size(gen_sx), eff_size(gen_sy), eff_size(gen_sz), a);
        for (int k = 0; k < 8; k++)
            if (!loaded[a[k]]) push_write(a[k], 16'($urandom));
        n_gen++;
        pending_words.push_back(w);
    endtask

    // mostly near the low corner or the far edge so few voxels need loading
    function automatic int rand_coord(int n);
        case ($urandom_range(0, 9))
            0: return int'($signed(20'($urandom)));
            1: return $urandom_range(0, 1) ? 524287 : -524288;
            2: return (n - 1) * 256 + int'($urandom_range(0, 511)) - 256;
            default: return int'($urandom_range(0, 768)) - 256;
        endcase
    endfunction

    task automatic set_sizes(int sx, int sy, int sz);
        pending_regs.push_back('{tvs_pkg::REG_SIZE_X, 7'(sx)});
        pending_regs.push_back('{tvs_pkg::REG_SIZE_Y, 7'(sy)});
        pending_regs.push_back('{tvs_pkg::REG_SIZE_Z, 7'(sz)});
        gen_sx = sx;
        gen_sy = sy;
        gen_sz = sz;
    endtask

    task automatic wait_idle();
        while (pending_words.size() != 0 || s_tvalid || expected_samples.size() != 0
               || pending_regs.size() != 0 || cfg_valid)
            @(posedge aclk);
        repeat (DRAIN) @(posedge aclk);
    endtask

    // queues about n words, neighbor loads included
    task automatic random_phase(int n);
        int ex, ey, ez, stop;
        ex = eff_size(gen_sx);
        ey = eff_size(gen_sy);
        ez = eff_size(gen_sz);
        stop = n_gen + n;
        while (n_gen < stop) begin
            if ($urandom_range(0, 3) == 0)
                push_write($urandom_range(0, ex * ey * ez - 1), 16'($urandom));
            else if ($urandom_range(0, 19) == 0)
                push_write($urandom_range(0, DEPTH - 1), 16'($urandom));
            else
                push_sample(rand_coord(ex), rand_coord(ey), rand_coord(ez));
        end
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    initial begin
        aclk = 0;
        forever #2 aclk = ~aclk;
    end

    // sender
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 0;
            s_tdata  <= '0;
            s_tuser  <= 0;
            send_gap <= 0;
        end else if (!s_tvalid || s_tready) begin
            if (s_tvalid) begin
                if (cur_word.mode == MODE_WRITE) begin
                    vol_store[cur_word.addr] = cur_word.voxel;
                    n_writes++;
                end else begin
                    expected_samples.push_back(interp_sample(cur_word));
                    n_samples++;
                end
            end
            if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                s_tvalid <= 0;
            end else if (pending_words.size() != 0 && !hold_send) begin
                cur_word = pending_words.pop_front();
                s_tdata  <= {2'b00, cur_word.cz, cur_word.cy, cur_word.cx,
                             cur_word.voxel, cur_word.addr};
                s_tuser  <= cur_word.mode;
                s_tvalid <= 1;
                send_gap <= no_idle ? 0 : pick_gap();
            end else begin
                s_tvalid <= 0;
            end
        end
    end

    // register writes
    always @(posedge aclk) begin
        if (!aresetn) begin
            cfg_valid <= 0;
            cfg_index <= '0;
            cfg_data  <= '0;
        end else if (!cfg_valid || cfg_ready) begin
            if (cfg_valid) begin
                case (cfg_index)
                    tvs_pkg::REG_SIZE_X: pred_sx = cfg_data;
                    tvs_pkg::REG_SIZE_Y: pred_sy = cfg_data;
                    tvs_pkg::REG_SIZE_Z: pred_sz = cfg_data;
                    default: ;
                endcase
                n_regs++;
            end
            if (pending_regs.size() != 0) begin
                reg_wr_t r;
                r = pending_regs.pop_front();
                cfg_index <= r.idx;
                cfg_data  <= r.val;
                cfg_valid <= 1;
            end else begin
                cfg_valid <= 0;
            end
        end
    end

    // result checker
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 0;
            recv_gap <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                n_results++;
                if (expected_samples.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected sample word: got %h", m_tdata);
                end else begin
                    logic [15:0] exp_v;
                    exp_v = expected_samples.pop_front();
                    if (m_tdata !== exp_v) begin
                        errors++;
                        if (errors <= 10)
                            $display("sample mismatch: expected %h got %h", exp_v, m_tdata);
                    end
                end
            end
            if (recv_gap > 0) begin
                recv_gap <= recv_gap - 1;
                m_tready <= 0;
            end else begin
                m_tready <= 1;
                recv_gap <= no_idle ? 0 : pick_gap();
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles >= LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        cycles = 0; errors = 0; n_samples = 0; n_writes = 0; n_regs = 0; n_results = 0;
        n_gen = 0;
        hold_send = 0; no_idle = 0;
        pred_sx = 7'd64; pred_sy = 7'd64; pred_sz = 7'd64;
        gen_sx = 64; gen_sy = 64; gen_sz = 64;
        foreach (loaded[i]) loaded[i] = 0;
        aresetn = 0;
        repeat (9) @(posedge aclk);
        aresetn <= 1;

        // directed: corners, extreme coordinates and fractions at reset sizes
        push_write(0, 16'h0000);
        push_write(DEPTH - 1, 16'hffff);
        push_sample(0, 0, 0);
        push_sample(255, 255, 255);
        push_sample(63 * 256 + 255, 63 * 256 + 255, 63 * 256 + 255);
        push_sample(524287, 524287, 524287);
        push_sample(-524288, -524288, -524288);
        push_sample(-1, -1, -1);
        push_sample(62 * 256 + 128, 1, 40 * 256 + 255);
        push_write(1, 16'hffff);
        push_write(64, 16'hffff);
        push_sample(128, 128, 0);
        push_sample(255, 0, 0);
        wait_idle();

        // zero sizes read as 1, oversize saturates, unused index ignored
        pending_regs.push_back('{REG_UNUSED, 7'($urandom)});
        set_sizes(0, 127, 1);
        wait_idle();
        push_sample(300, 70 * 256 + 17, -3000);
        push_sample(-524288, 524287, 0);
        push_write(5, 16'h8000);
        push_sample(5 * 256 + 200, 0, 0);
        wait_idle();

        set_sizes(1, 1, 1);
        wait_idle();
        random_phase(120);
        wait_idle();

        set_sizes(64, 64, 64);
        wait_idle();
        random_phase(250);
        // sender holds off until the block has drained
        while (pending_words.size() > 120) @(posedge aclk);
        hold_send = 1;
        while (s_tvalid || expected_samples.size() != 0) @(posedge aclk);
        hold_send = 0;
        wait_idle();

        set_sizes(3, 64, 2);
        wait_idle();
        no_idle = 1;
        random_phase(200);
        wait_idle();
        no_idle = 0;

        set_sizes(64, 1, 127);
        wait_idle();
        random_phase(200);
        wait_idle();

        for (int p = 0; p < 4; p++) begin
            set_sizes($urandom_range(0, 127), $urandom_range(0, 127), $urandom_range(0, 127));
            wait_idle();
            random_phase(150);
            wait_idle();
        end

        while (expected_samples.size() != 0) @(posedge aclk);
        repeat (DRAIN) @(posedge aclk);
        if (expected_samples.size() != 0) errors++;
        $display("covered %0d samples, %0d voxel writes, %0d register writes, %0d checked",
                 n_samples, n_writes, n_regs, n_results);
        $display("mismatches: %0d", errors);
        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule
